[design/assert_macros.svh]
// assertion helpers used by the core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PWCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by another in the next cycle
`define PWCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/pwcs_pkg.sv]
`timescale 1ns / 1ps
package pwcs_pkg;

  // block constants
  localparam int NUM_CHANNELS  = 4;
  localparam int MAX_CHANNELS  = 4;
  localparam int SCALED_RANGE  = 1000;
  localparam int TIMEOUT_TICKS = 100;

  // field widths
  localparam int CHAN_W    = 2;
  localparam int STAMP_W   = 16;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 2 * STAMP_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITERS = PROD_W / DIV_STEPS;
  localparam int ITER_W    = $clog2(DIV_ITERS);

  // input operation codes
  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_TICK    = 1'b1
  } pwcs_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_LOAD
  } pwcs_state_e;

  // sequencer controls
  typedef struct packed {
    logic in_ready;
    logic load_mult;
    logic div_step;
    logic load_out;
  } pwcs_ctrl_t;

endpackage

[design/pwcs_channels.sv]
`timescale 1ns / 1ps

// capture and tick words
interface pwcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [pwcs_pkg::CHAN_W-1:0]   chan;
  logic [pwcs_pkg::STAMP_W-1:0]  stamp;

  modport source (output valid, operation, chan, stamp, input ready);
  modport sink (input valid, operation, chan, stamp, output ready);
endinterface

// measurement words
interface pwcs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pwcs_pkg::CHAN_W-1:0]          chan_out;
  logic                                 value_valid;
  logic [pwcs_pkg::STAMP_W-1:0]         raw_width;
  logic [pwcs_pkg::STAMP_W-1:0]         scaled_value;
  logic [pwcs_pkg::MAX_CHANNELS-1:0]    present_mask;

  modport source (output valid, chan_out, value_valid, raw_width, scaled_value,
                  present_mask, input ready);
  modport sink (input valid, chan_out, value_valid, raw_width, scaled_value,
                present_mask, output ready);
endinterface

// register write words
interface pwcs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pwcs_pkg::CFG_IDX_W-1:0]   index;
  logic [pwcs_pkg::STAMP_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/pulse_width_capture_scaler_core.sv]
// sequence: a falling-edge word takes a multiply, 16 radix-4 divide steps and an output
//   load; zero-scaled widths skip the divide, other words go straight to the output load
// input: no new word is taken until the current one is loaded, the divider is shared;
//   an output stall holds the output load and so the input as well
// reset: sequencer, output valid, stamps and silence counters clear at once, edge flags
//   expect a rising edge, limits return to min 0 and max 65535; no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_width_capture_scaler_core #(
  parameter int NumChannels = pwcs_pkg::NUM_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pwcs_in_if.sink       item_i,
  pwcs_out_if.source    result_o,
  pwcs_cfg_if.sink      cfg_i
);
  import pwcs_pkg::*;

  localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam logic [CNT_W-1:0]   TimeoutCnt = CNT_W'(TIMEOUT_TICKS);
  localparam logic [STAMP_W-1:0] RangeW     = STAMP_W'(SCALED_RANGE);
  localparam logic [ITER_W-1:0]  IterLast   = ITER_W'(DIV_ITERS - 1);

  // per channel state and limits
  logic                expect_rising_q [NumChannels];
  logic [STAMP_W-1:0]  rise_stamp_q    [NumChannels];
  logic [CNT_W-1:0]    silence_q       [NumChannels];
  logic [STAMP_W-1:0]  lo_q            [NumChannels];
  logic [STAMP_W-1:0]  hi_q            [NumChannels];

  pwcs_state_e         state_q, state_d;
  pwcs_ctrl_t          ctrl;

  // working registers
  logic [CHAN_W-1:0]   chan_q;
  logic                fall_q;
  logic [STAMP_W-1:0]  raw_q;
  logic [STAMP_W-1:0]  lo_sel_q;
  logic [STAMP_W-1:0]  hi_sel_q;
  logic [PROD_W-1:0]   num_q;
  logic [STAMP_W-1:0]  dvs_q;
  logic [STAMP_W-1:0]  rem_q;
  logic [ITER_W-1:0]   iter_q;

  // output register
  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_chan_q;
  logic                out_vv_q;
  logic [STAMP_W-1:0]  out_raw_q;
  logic [STAMP_W-1:0]  out_scaled_q;
  logic [MAX_CHANNELS-1:0] out_mask_q;

  logic                accept;
  logic                is_tick;
  logic                chan_ok;
  logic [ChIdxW-1:0]   ch_idx;
  logic                is_fall;
  logic [STAMP_W-1:0]  width_d;
  logic                scale_zero;
  logic [STAMP_W-1:0]  diff_w;
  logic [PROD_W-1:0]   prod_w;
  logic [PROD_W-1:0]   num_d;
  logic [STAMP_W-1:0]  rem_d;
  logic [STAMP_W-1:0]  scaled_w;
  logic [MAX_CHANNELS-1:0] mask_w;
  logic                cfg_hit;
  logic [ChIdxW-1:0]   cfg_ch;
  logic                div_last;
  logic                out_blank;

  // capture decode
  assign accept  = item_i.valid & item_i.ready;
  assign is_tick = (item_i.operation == OP_TICK);
  assign chan_ok = (32'(item_i.chan) < NumChannels);
  assign ch_idx  = item_i.chan[ChIdxW-1:0];
  assign is_fall = !is_tick && chan_ok && !expect_rising_q[ch_idx];
  assign width_d = item_i.stamp - rise_stamp_q[ch_idx];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = is_fall ? ST_MULT : ST_LOAD;
      end
      ST_MULT: begin
        state_d = scale_zero ? ST_LOAD : ST_DIV;
      end
      ST_DIV: begin
        if (iter_q == IterLast) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: ctrl.in_ready  = 1'b1;
      ST_MULT: ctrl.load_mult = 1'b1;
      ST_DIV:  ctrl.div_step  = 1'b1;
      ST_LOAD: ctrl.load_out  = !out_valid_q || result_o.ready;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign item_i.ready = ctrl.in_ready;

  // channel state update on accepted words
  for (genvar i = 0; i < NumChannels; i++) begin : g_chan
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        expect_rising_q[i] <= 1'b1;
        rise_stamp_q[i]    <= '0;
        silence_q[i]       <= '0;
      end else if (accept) begin
        if (is_tick) begin
          if (silence_q[i] < TimeoutCnt) silence_q[i] <= silence_q[i] + 1'b1;
        end else if (chan_ok && (ch_idx == ChIdxW'(i))) begin
          silence_q[i]       <= '0;
          expect_rising_q[i] <= !expect_rising_q[i];
          if (expect_rising_q[i]) rise_stamp_q[i] <= item_i.stamp;
        end
      end
    end
  end

  // limit registers
  assign cfg_i.ready = 1'b1;
  assign cfg_hit     = (32'(cfg_i.index) < 2 * NumChannels);
  assign cfg_ch      = cfg_i.index[ChIdxW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '1;
      end
    end else if (cfg_i.valid && cfg_hit) begin
      if (cfg_i.index[0]) hi_q[cfg_ch] <= cfg_i.data;
      else lo_q[cfg_ch] <= cfg_i.data;
    end
  end

  // width minus min, times range
  assign scale_zero = (hi_sel_q <= lo_sel_q) || (raw_q <= lo_sel_q);
  assign diff_w     = raw_q - lo_sel_q;
  assign prod_w     = {{STAMP_W{1'b0}}, diff_w} * {{STAMP_W{1'b0}}, RangeW};

  // two restoring divide steps per cycle
  always_comb begin
    logic [STAMP_W:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_d, num_d[PROD_W-1]};
      num_d = {num_d[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = STAMP_W'(trial - {1'b0, dvs_q});
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[STAMP_W-1:0];
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q   <= is_tick ? '0 : item_i.chan;
      fall_q   <= is_fall;
      raw_q    <= is_fall ? width_d : '0;
      lo_sel_q <= lo_q[ch_idx];
      hi_sel_q <= hi_q[ch_idx];
      num_q    <= '0;
    end
    if (ctrl.load_mult) begin
      num_q  <= scale_zero ? '0 : prod_w;
      dvs_q  <= hi_sel_q - lo_sel_q;
      rem_q  <= '0;
      iter_q <= '0;
    end
    if (ctrl.div_step) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      iter_q <= iter_q + 1'b1;
    end
  end

  // clamp and presence mask
  assign scaled_w = (num_q > PROD_W'(SCALED_RANGE)) ? RangeW : num_q[STAMP_W-1:0];

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_mask
    if (i < NumChannels) begin : g_live
      assign mask_w[i] = (silence_q[i] < TimeoutCnt);
    end else begin : g_dead
      assign mask_w[i] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      out_chan_q   <= chan_q;
      out_vv_q     <= fall_q;
      out_raw_q    <= raw_q;
      out_scaled_q <= fall_q ? scaled_w : '0;
      out_mask_q   <= mask_w;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.chan_out     = out_chan_q;
  assign result_o.value_valid  = out_vv_q;
  assign result_o.raw_width    = out_raw_q;
  assign result_o.scaled_value = out_scaled_q;
  assign result_o.present_mask = out_mask_q;

  // checks
  assign div_last  = (state_q == ST_DIV) && (iter_q == IterLast);
  assign out_blank = (out_raw_q == '0) && (out_scaled_q == '0);

  `PWCS_ASSERT(a_scaled_in_range, !out_valid_q || (out_scaled_q <= RangeW), "scaled above range")
  `PWCS_ASSERT(a_idle_word_zero, !out_valid_q || out_vv_q || out_blank, "idle word carries data")
  `PWCS_ASSERT_NEXT(a_div_ends, div_last, state_q == ST_LOAD, "divider did not finish")
  `PWCS_ASSERT(a_silence_bound, silence_q[0] <= TimeoutCnt, "silence counter beyond limit")

endmodule
